// ----- rtl/sbs_pkg.sv -----
// types and constants shared by the score byte sequencer files
package sbs_pkg;

	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_LOAD   = 3'd1,
		REQ_START  = 3'd2,
		REQ_STOP   = 3'd3,
		REQ_PAUSE  = 3'd4,
		REQ_RESUME = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		KIND_ACK      = 2'd0,
		KIND_NOTE_ON  = 2'd1,
		KIND_ALL_OFF  = 2'd2
	} event_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STOP,
		ST_CHECK,
		ST_CMD,
		ST_NOTE,
		ST_DELAY,
		ST_END
	} seq_state_t;

	localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
	localparam logic [3:0] CMD_END       = 4'hF;
	localparam logic [6:0] NOTE_VELOCITY = 7'd100;
	localparam logic [3:0] LAST_CHANNEL  = 4'd15;

endpackage

// ----- rtl/score_byte_sequencer_core.sv -----
// score byte sequencer: score memory, decode sequencer and result register
//
//  channel   signals                                        transfer when
//  request   start, busy, req_type, score_address,          start && !busy
//            score_byte
//  result    result_valid, event_kind, channel, note,       result_valid (one cycle)
//            velocity, last
//  config    score_length_we, score_length                  score_length_we
//
// a request that gives one result goes through the end state; stop emits an all-off per channel
// a decoding tick checks the cap, time mark and length, fetches each command byte, then the note
// byte of a note event or the second byte of a delay, and ends through the end state when the
// end code, a delay, the score end, the event cap, the time mark or the length stops it
// ignored codes do not count against the cap, so a run of them only lengthens the tick
// each byte fetched comes through the registered read of the score memory
// results appear in the cycle after the sequencer produces them, one per cycle at most
// reset clears all control state; score memory contents are undefined until loaded
module score_byte_sequencer_core
	import sbs_pkg::*;
#(
	parameter int SCORE_DEPTH         = 1024,
	parameter int MAX_EVENTS_PER_STEP = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [9:0]  score_address,
	input  logic [7:0]  score_byte,
	input  logic        score_length_we,
	input  logic [10:0] score_length,
	output logic        result_valid,
	output logic [1:0]  event_kind,
	output logic [3:0]  channel,
	output logic [7:0]  note,
	output logic [6:0]  velocity,
	output logic        last
);

	localparam int AW = $clog2(SCORE_DEPTH);
	localparam int CW = $clog2(MAX_EVENTS_PER_STEP + 1);
	localparam logic [31:0] DEPTH32 = 32'(SCORE_DEPTH);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EVENTS_PER_STEP);

	seq_state_t state_q, state_d;

	logic [10:0]   len_q;
	logic [10:0]   pos_q, pos_d;
	logic [31:0]   tick_q, tick_d;
	logic [31:0]   net_q, net_d;
	logic          playing_q, playing_d;
	logic          finished_q, finished_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [3:0]    chan_q, chan_d;
	logic [6:0]    dly_q, dly_d;
	logic          pend_vld_q, pend_vld_d;
	event_kind_t   pend_kind_q, pend_kind_d;
	logic [7:0]    pend_note_q, pend_note_d;

	logic [7:0]    mem [SCORE_DEPTH];
	logic [7:0]    rdata_q;
	logic          mem_we;
	logic [AW-1:0] rd_addr;

	logic          emit;
	event_kind_t   emit_kind;
	logic [3:0]    emit_chan;
	logic [7:0]    emit_note;
	logic          emit_last;

	logic [10:0]   len_eff;
	logic          run_ok;
	logic          at_end;
	logic          accept;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign len_eff = ({21'd0, len_q} > DEPTH32) ? 11'(SCORE_DEPTH) : len_q;
	assign at_end  = (pos_q >= len_eff);
	assign run_ok  = (cnt_q < MAX_CNT) && !at_end && (tick_q >= net_q);
	assign rd_addr = AW'(pos_q);
	assign mem_we  = accept && (req_type == REQ_LOAD) && ({22'd0, score_address} < DEPTH32);

	// score memory, at most one write and one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(score_address)] <= score_byte;
		end
		rdata_q <= mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_STOP) begin
						state_d = ST_STOP;
					end else if (req_type == REQ_TICK && playing_q && !finished_q) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_END;
					end
				end
			end
			ST_STOP: begin
				if (chan_q == LAST_CHANNEL) begin
					state_d = ST_IDLE;
				end
			end
			ST_CHECK: begin
				state_d = run_ok ? ST_CMD : ST_END;
			end
			ST_CMD: begin
				priority if (!rdata_q[7]) begin
					state_d = at_end ? ST_END : ST_DELAY;
				end else if (rdata_q[7:4] == CMD_NOTE_ON) begin
					state_d = at_end ? ST_END : ST_NOTE;
				end else if (rdata_q[7:4] == CMD_END) begin
					state_d = ST_END;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_NOTE:  state_d = ST_CHECK;
			ST_DELAY: state_d = ST_END;
			ST_END:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath control and result generation
	always_comb begin
		pos_d       = pos_q;
		tick_d      = tick_q;
		net_d       = net_q;
		playing_d   = playing_q;
		finished_d  = finished_q;
		cnt_d       = cnt_q;
		chan_d      = chan_q;
		dly_d       = dly_q;
		pend_vld_d  = pend_vld_q;
		pend_kind_d = pend_kind_q;
		pend_note_d = pend_note_q;
		emit        = 1'b0;
		emit_kind   = KIND_ACK;
		emit_chan   = 4'd0;
		emit_note   = 8'd0;
		emit_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cnt_d      = '0;
					chan_d     = 4'd0;
					pend_vld_d = 1'b0;
					unique case (req_type)
						REQ_TICK: begin
							if (playing_q) begin
								tick_d = tick_q + 32'd1;
							end
						end
						REQ_START: begin
							tick_d     = '0;
							pos_d      = '0;
							net_d      = '0;
							finished_d = 1'b0;
							playing_d  = 1'b1;
						end
						REQ_STOP: begin
							playing_d  = 1'b0;
							finished_d = 1'b1;
						end
						REQ_PAUSE:  playing_d = 1'b0;
						REQ_RESUME: playing_d = 1'b1;
						default: ;
					endcase
				end
			end
			ST_STOP: begin
				emit      = 1'b1;
				emit_kind = KIND_ALL_OFF;
				emit_chan = chan_q;
				emit_last = (chan_q == LAST_CHANNEL);
				chan_d    = chan_q + 4'd1;
			end
			ST_CHECK: begin
				// read of the command byte is issued at rd_addr this cycle
				if (run_ok) begin
					pos_d = pos_q + 11'd1;
				end
			end
			ST_CMD: begin
				priority if (!rdata_q[7]) begin
					dly_d = rdata_q[6:0];
					if (!at_end) begin
						pos_d = pos_q + 11'd1;
					end
				end else if (rdata_q[7:4] == CMD_NOTE_ON) begin
					if (!at_end) begin
						pos_d = pos_q + 11'd1;
					end
				end else if (rdata_q[7:4] == CMD_END) begin
					finished_d  = 1'b1;
					playing_d   = 1'b0;
					emit        = pend_vld_q;
					emit_kind   = pend_kind_q;
					emit_note   = pend_note_q;
					pend_vld_d  = 1'b1;
					pend_kind_d = KIND_ALL_OFF;
					pend_note_d = 8'd0;
					cnt_d       = cnt_q + CW'(1);
				end else begin
				end
			end
			ST_NOTE: begin
				// hold each event back one step so the final one can carry last
				emit        = pend_vld_q;
				emit_kind   = pend_kind_q;
				emit_note   = pend_note_q;
				pend_vld_d  = 1'b1;
				pend_kind_d = KIND_NOTE_ON;
				pend_note_d = rdata_q;
				cnt_d       = cnt_q + CW'(1);
			end
			ST_DELAY: begin
				net_d = tick_q + {17'd0, dly_q, rdata_q};
			end
			ST_END: begin
				emit       = 1'b1;
				emit_kind  = pend_vld_q ? pend_kind_q : KIND_ACK;
				emit_note  = pend_vld_q ? pend_note_q : 8'd0;
				emit_last  = 1'b1;
				pend_vld_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= '0;
			pos_q        <= '0;
			tick_q       <= '0;
			net_q        <= '0;
			playing_q    <= 1'b0;
			finished_q   <= 1'b0;
			cnt_q        <= '0;
			chan_q       <= '0;
			pend_vld_q   <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			pos_q        <= pos_d;
			tick_q       <= tick_d;
			net_q        <= net_d;
			playing_q    <= playing_d;
			finished_q   <= finished_d;
			cnt_q        <= cnt_d;
			chan_q       <= chan_d;
			pend_vld_q   <= pend_vld_d;
			result_valid <= emit;
			if (score_length_we) begin
				len_q <= score_length;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		dly_q       <= dly_d;
		pend_kind_q <= pend_kind_d;
		pend_note_q <= pend_note_d;
		event_kind  <= emit_kind;
		channel     <= emit_chan;
		note        <= emit_note;
		velocity    <= (emit_kind == KIND_NOTE_ON) ? NOTE_VELOCITY : 7'd0;
		last        <= emit_last;
	end

endmodule

// ----- rtl/sbs_checker.sv -----
// port-level checks for the score byte sequencer and their binding
module sbs_checker
	import sbs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_valid,
	input logic [1:0] event_kind,
	input logic [3:0] channel,
	input logic [6:0] velocity,
	input logic       last
);

	// an accepted request always makes the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// a non-final result of a request always comes while the block is still busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final result outside of a busy request");

	// nothing follows directly after the final result
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result right after final result");

	a_note_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_kind == KIND_NOTE_ON |-> velocity == NOTE_VELOCITY && channel == 4'd0)
		else $error("note on with wrong velocity or channel");

	a_ack_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_kind == KIND_ACK |-> last)
		else $error("acknowledge not marked last");

endmodule

bind score_byte_sequencer_core sbs_checker u_sbs_checker (.*);

// ----- tb/sbs_event_checker.sv -----
`timescale 1ns / 100ps
// score sequencer checker: predicts the result stream from observed requests and compares it
module sbs_event_checker
	import sbs_pkg::*;
#(
	parameter int SCORE_DEPTH         = 1024,
	parameter int MAX_EVENTS_PER_STEP = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  req_type,
	input  logic [9:0]  score_address,
	input  logic [7:0]  score_byte,
	input  logic        score_length_we,
	input  logic [10:0] score_length,
	input  logic        result_valid,
	input  logic [1:0]  event_kind,
	input  logic [3:0]  channel,
	input  logic [7:0]  note,
	input  logic [6:0]  velocity,
	input  logic        last,
	output int          open_count,
	output int          fail_count
);

	typedef struct packed {
		event_kind_t kind;
		logic [3:0]  chan;
		logic [7:0]  note;
		logic [6:0]  vel;
		logic        last;
	} score_event_t;

	score_event_t expected_events[$];
	score_event_t request_events[$];

	logic [7:0]  score_mem [0:SCORE_DEPTH-1];
	logic [10:0] length_reg = '0;
	logic [10:0] play_pos   = '0;
	logic [31:0] tick_count = '0;
	logic [31:0] event_time = '0;
	bit          playing    = 1'b0;
	bit          finished   = 1'b0;
	int          fails      = 0;

	assign fail_count = fails;

	function automatic score_event_t make_event(input event_kind_t kind, input logic [3:0] chan,
			input logic [7:0] nt, input logic [6:0] vel);
		score_event_t ev;
		ev.kind = kind;
		ev.chan = chan;
		ev.note = nt;
		ev.vel  = vel;
		ev.last = 1'b0;
		return ev;
	endfunction

	function automatic int field_differs(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	// walk the score from the current position until a delay, the end code, the event cap, the length or the time mark
	task play_score_tick;
		int         lim;
		int         emitted;
		bit         done;
		logic [7:0] code;
		lim = (length_reg > SCORE_DEPTH) ? SCORE_DEPTH : int'(length_reg);
		emitted = 0;
		done = 1'b0;
		while (!done && emitted < MAX_EVENTS_PER_STEP && play_pos < lim &&
				tick_count >= event_time) begin
			code = score_mem[play_pos];
			play_pos++;
			if (!code[7]) begin
				// lone delay byte at score end is consumed and stops decoding
				if (play_pos < lim) begin
					event_time = tick_count + {17'd0, code[6:0], score_mem[play_pos]};
					play_pos++;
				end
				done = 1'b1;
			end else if (code[7:4] == CMD_NOTE_ON) begin
				if (play_pos < lim) begin
					request_events.push_back(make_event(KIND_NOTE_ON, 4'd0, score_mem[play_pos],
						NOTE_VELOCITY));
					play_pos++;
					emitted++;
				end else begin
					done = 1'b1;
				end
			end else if (code[7:4] == CMD_END) begin
				finished = 1'b1;
				playing = 1'b0;
				request_events.push_back(make_event(KIND_ALL_OFF, 4'd0, 8'd0, 7'd0));
				emitted++;
				done = 1'b1;
			end
		end
	endtask

	task handle_request(input logic [2:0] kind_in, input logic [9:0] addr,
			input logic [7:0] data);
		score_event_t tail;
		request_events.delete();
		case (kind_in)
			REQ_TICK: begin
				if (playing) begin
					tick_count++;
					if (!finished)
						play_score_tick();
				end
			end
			REQ_LOAD: score_mem[addr] = data;
			REQ_START: begin
				tick_count = '0;
				play_pos = '0;
				event_time = '0;
				finished = 1'b0;
				playing = 1'b1;
			end
			REQ_STOP: begin
				for (int ch = 0; ch <= LAST_CHANNEL; ch++)
					request_events.push_back(make_event(KIND_ALL_OFF, ch[3:0], 8'd0, 7'd0));
				playing = 1'b0;
				finished = 1'b1;
			end
			REQ_PAUSE: playing = 1'b0;
			REQ_RESUME: playing = 1'b1;
			default: ;
		endcase
		if (request_events.size() == 0)
			request_events.push_back(make_event(KIND_ACK, 4'd0, 8'd0, 7'd0));
		tail = request_events.pop_back();
		tail.last = 1'b1;
		request_events.push_back(tail);
		foreach (request_events[i])
			expected_events.push_back(request_events[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		score_event_t want;
		int           bad;
		if (!arst_n) begin
			expected_events.delete();
			length_reg = '0;
			play_pos = '0;
			tick_count = '0;
			event_time = '0;
			playing = 1'b0;
			finished = 1'b0;
			open_count <= 0;
		end else begin
			// a result in this cycle belongs to an earlier transfer, so compare first
			if (result_valid) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected result, expected none, got kind %0d channel %0d note %0d",
						$time, event_kind, channel, note);
					fails++;
				end else begin
					want = expected_events.pop_front();
					bad = field_differs("event_kind", want.kind, event_kind)
						+ field_differs("channel", want.chan, channel)
						+ field_differs("note", want.note, note)
						+ field_differs("velocity", want.vel, velocity)
						+ field_differs("last", want.last, last);
					if (bad != 0)
						fails++;
				end
			end
			if (score_length_we)
				length_reg = score_length;
			if (start && !busy)
				handle_request(req_type, score_address, score_byte);
			open_count <= expected_events.size();
		end
	end

endmodule

// ----- tb/tb_score_byte_sequencer_core.sv -----
`timescale 1ns / 100ps
// testbench top for the score byte sequencer: request stimulus, length writes and verdict
module tb_score_byte_sequencer_core;
	import sbs_pkg::*;

	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam logic [3:0] CMD_IGNORED  = 4'h8;
	localparam logic [3:0] CMD_OTHER    = 4'hE;
	localparam int SCORE_SPAN    = 1024;
	localparam int MAX_ADDR      = 1023;
	localparam int LENGTH_MAX    = 2047;
	localparam int RANDOM_ITEMS  = 330;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 60;

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        start           = 1'b0;
	logic        busy;
	logic [2:0]  req_type        = '0;
	logic [9:0]  score_address   = '0;
	logic [7:0]  score_byte      = '0;
	logic        score_length_we = 1'b0;
	logic [10:0] score_length    = '0;
	logic        result_valid;
	logic [1:0]  event_kind;
	logic [3:0]  channel;
	logic [7:0]  note;
	logic [6:0]  velocity;
	logic        last;
	int          open_count;
	int          fail_count;

	int          idle_cycles = 0;
	int          burst_left  = 0;
	int          sent        = 0;
	logic [7:0]  image [0:SCORE_SPAN-1];
	bit          loaded [0:SCORE_SPAN-1];
	logic [7:0]  score_q[$];

	score_byte_sequencer_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.score_address  (score_address),
		.score_byte     (score_byte),
		.score_length_we(score_length_we),
		.score_length   (score_length),
		.result_valid   (result_valid),
		.event_kind     (event_kind),
		.channel        (channel),
		.note           (note),
		.velocity       (velocity),
		.last           (last)
	);

	sbs_event_checker event_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.score_address  (score_address),
		.score_byte     (score_byte),
		.score_length_we(score_length_we),
		.score_length   (score_length),
		.result_valid   (result_valid),
		.event_kind     (event_kind),
		.channel        (channel),
		.note           (note),
		.velocity       (velocity),
		.last           (last),
		.open_count     (open_count),
		.fail_count     (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// no transfer in either direction for too long means the block hung
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task issue(input logic [2:0] kind, input logic [9:0] addr, input logic [7:0] data);
		int gap;
		start <= 1'b1;
		req_type <= kind;
		score_address <= addr;
		score_byte <= data;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (kind == REQ_LOAD) begin
			image[addr] = data;
			loaded[addr] = 1'b1;
		end
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		end
	endtask

	// hold off until every expected result is back and the block has gone quiet
	task drain;
		start <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task set_length(input logic [10:0] value);
		score_length_we <= 1'b1;
		score_length <= value;
		@(posedge clk);
		score_length_we <= 1'b0;
	endtask

	function automatic int written_prefix();
		int n;
		n = 0;
		while (n < SCORE_SPAN && loaded[n])
			n++;
		return n;
	endfunction

	// how far playback from address 0 can read under this length; -1 if it would hit
	// a location that was never loaded
	function automatic int score_reach(input int cfg_len);
		int         lim;
		int         pos;
		bit         done;
		bit         bad;
		logic [7:0] code;
		lim = (cfg_len > SCORE_SPAN) ? SCORE_SPAN : cfg_len;
		pos = 0;
		done = 1'b0;
		bad = 1'b0;
		while (!done && pos < lim) begin
			if (!loaded[pos]) begin
				bad = 1'b1;
				done = 1'b1;
			end else begin
				code = image[pos];
				pos++;
				if (code[7:4] == CMD_END) begin
					done = 1'b1;
				end else if ((code[7:4] == CMD_NOTE_ON || !code[7]) && pos < lim) begin
					if (!loaded[pos]) begin
						bad = 1'b1;
						done = 1'b1;
					end else begin
						pos++;
					end
				end
			end
		end
		return bad ? -1 : pos;
	endfunction

	task build_score(input int phase);
		int          events;
		int          pick;
		logic [31:0] rnd;
		score_q.delete();
		if (phase == 0 || $urandom_range(0, 3) == 0) begin
			// long note run to hit the per-tick event cap
			events = $urandom_range(17, 24);
			for (int k = 0; k < events; k++) begin
				rnd = $urandom;
				score_q.push_back({CMD_NOTE_ON, rnd[3:0]});
				score_q.push_back(rnd[15:8]);
			end
		end else begin
			events = $urandom_range(3, 14);
			for (int k = 0; k < events; k++) begin
				pick = $urandom_range(0, 9);
				rnd = $urandom;
				if (pick < 5) begin
					score_q.push_back({CMD_NOTE_ON, rnd[3:0]});
					score_q.push_back(rnd[15:8]);
				end else if (pick == 5) begin
					score_q.push_back({CMD_IGNORED, rnd[3:0]});
				end else if (pick == 6) begin
					rnd = $urandom_range(8'hA0, 8'hEF);
					score_q.push_back(rnd[7:0]);
				end else if (rnd[31:29] == 3'd0) begin
					// long delay, usually stalls the song until stop
					score_q.push_back({1'b0, rnd[6:0]});
					score_q.push_back(rnd[15:8]);
				end else begin
					score_q.push_back(8'h00);
					score_q.push_back({6'd0, rnd[1:0]});
				end
			end
		end
		rnd = $urandom;
		if (phase != 6 && (phase < 8 || $urandom_range(0, 2) != 0))
			score_q.push_back({CMD_END, rnd[3:0]});
	endtask

	initial begin : stimulus
		int target;
		int phase;
		int size;
		int choice;
		int cfg_len;
		int reach;
		int floor_addr;
		int plays;
		int roll;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		issue(REQ_SPARE_LO, 10'd0, 8'd0);
		issue(REQ_TICK, 10'(MAX_ADDR), 8'hFF);
		issue(REQ_RESUME, 10'd0, 8'd0);
		issue(REQ_TICK, 10'd0, 8'd0);
		issue(REQ_PAUSE, 10'd0, 8'd0);
		issue(REQ_TICK, 10'd0, 8'd0);
		// two notes at the note extremes, ignored codes, a delay of one, a note, end code
		issue(REQ_LOAD, 10'd0, {CMD_NOTE_ON, 4'h0});
		issue(REQ_LOAD, 10'd1, 8'h00);
		issue(REQ_LOAD, 10'd2, {CMD_NOTE_ON, 4'hF});
		issue(REQ_LOAD, 10'd3, 8'hFF);
		issue(REQ_LOAD, 10'd4, {CMD_IGNORED, 4'hA});
		issue(REQ_LOAD, 10'd5, {CMD_OTHER, 4'h3});
		issue(REQ_LOAD, 10'd6, 8'h00);
		issue(REQ_LOAD, 10'd7, 8'h01);
		issue(REQ_LOAD, 10'd8, {CMD_NOTE_ON, 4'h5});
		issue(REQ_LOAD, 10'd9, 8'h40);
		issue(REQ_LOAD, 10'd10, {CMD_END, 4'h0});
		drain;
		set_length(11'd11);
		issue(REQ_START, 10'd0, 8'd0);
		issue(REQ_TICK, 10'd0, 8'd0);
		issue(REQ_TICK, 10'd0, 8'd0);
		issue(REQ_TICK, 10'd0, 8'd0);
		issue(REQ_RESUME, 10'd0, 8'd0);
		issue(REQ_TICK, 10'd0, 8'd0);
		issue(REQ_STOP, 10'd0, 8'd0);
		// length cuts the last note command off its note byte
		drain;
		set_length(11'd9);
		issue(REQ_START, 10'd0, 8'd0);
		issue(REQ_TICK, 10'd0, 8'd0);
		issue(REQ_TICK, 10'd0, 8'd0);
		// length leaves the delay without its second byte
		drain;
		set_length(11'd7);
		issue(REQ_START, 10'd0, 8'd0);
		issue(REQ_TICK, 10'd0, 8'd0);
		issue(REQ_STOP, 10'd0, 8'd0);

		// directed requests count toward the total
		target = RANDOM_ITEMS;
		phase = 0;
		while (sent < target) begin
			build_score(phase);
			size = score_q.size();
			for (int k = 0; k < size; k++)
				issue(REQ_LOAD, 10'(k), score_q[k]);
			drain;
			choice = (phase < 8) ? 7 - phase : $urandom_range(0, 7);
			case (choice)
				0: cfg_len = 0;
				1: cfg_len = size;
				2: cfg_len = size - 1;
				3: cfg_len = $urandom_range(0, written_prefix());
				4: cfg_len = SCORE_SPAN;
				5: cfg_len = LENGTH_MAX;
				6: cfg_len = $urandom_range(SCORE_SPAN + 1, LENGTH_MAX);
				default: cfg_len = written_prefix();
			endcase
			reach = score_reach(cfg_len);
			if (reach < 0) begin
				cfg_len = written_prefix();
				reach = score_reach(cfg_len);
			end
			set_length(11'(cfg_len));
			// stray loads stay clear of anything playback can read
			floor_addr = (reach > size) ? reach : size;
			issue(REQ_START, 10'($urandom), 8'($urandom));
			plays = $urandom_range(12, 40);
			for (int k = 0; k < plays && sent < target; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 60)
					issue(REQ_TICK, 10'($urandom), 8'($urandom));
				else if (roll < 66)
					issue(REQ_START, 10'($urandom), 8'($urandom));
				else if (roll < 72)
					issue(REQ_PAUSE, 10'($urandom), 8'($urandom));
				else if (roll < 80)
					issue(REQ_RESUME, 10'($urandom), 8'($urandom));
				else if (roll < 83)
					issue(REQ_STOP, 10'($urandom), 8'($urandom));
				else if (roll < 92 && floor_addr <= MAX_ADDR)
					issue(REQ_LOAD, 10'($urandom_range(floor_addr, MAX_ADDR)), 8'($urandom));
				else
					issue($urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO, 10'($urandom),
						8'($urandom));
			end
			// stop leaves the song finished so a later resume cannot read a new score midway
			issue(REQ_STOP, 10'($urandom), 8'($urandom));
			phase++;
		end

		drain;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
